// ===== rtl/mstm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstm_pkg
// Shared types and constants of the timer table.
// ----------------------------------------------------------------------------
package mstm_pkg;

	localparam int unsigned DEF_TIMER_SLOTS = 16;
	localparam int unsigned ID_W = 16;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned OP_W = 3;
	localparam int unsigned ST_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_START   = 3'd0,
		OP_STOP    = 3'd1,
		OP_RESTART = 3'd2,
		OP_SETCYC  = 3'd3,
		OP_TICK    = 3'd4,
		OP_QUERY   = 3'd5,
		OP_CLEAR   = 3'd6,
		OP_NOP     = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	typedef struct packed {
		op_t                opcode;
		logic [ID_W-1:0]   job_id;
		logic [TICK_W-1:0] duration_ticks;
		logic               cyclic;
	} cmd_t;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]  expired_id;
		logic              expired_cyclic;
		status_t           status;
		logic              is_active;
		logic              last;
	} res_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_SCAN,
		EX_APPLY,
		EX_EMIT
	} ex_state_t;

endpackage

// ===== rtl/mstm_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstm_cmd_fifo
// Two-entry command queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module mstm_cmd_fifo
	import mstm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_word,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_word,
	output logic empty
);
	cmd_t        mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_word = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en && !full) wp_q <= ~wp_q;
			if (rd_en && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en && !full) - 2'(rd_en && !empty);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("command queue count out of range");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd_en |=> full)
		else $error("full queue drained without read");
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		empty && !wr_en |=> empty)
		else $error("empty queue filled without write");
`endif
endmodule

// ===== rtl/mstm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstm_engine
// Timer table and sequencer: scans one slot per cycle unless held; emits words.
// ----------------------------------------------------------------------------
module mstm_engine
	import mstm_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = DEF_TIMER_SLOTS,
	localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	output res_t res,
	output logic res_valid,
	input  logic res_ready
);
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [ID_W-1:0]        id_q   [TIMER_SLOTS];
	logic [TICK_W-1:0]      dur_q  [TIMER_SLOTS];
	logic [TICK_W-1:0]      ela_q  [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] cyc_q;

	ex_state_t state_q, state_d;
	cmd_t      cmd_q;
	logic [SW-1:0] idx_q;
	logic      hit_q, free_q;
	logic [SW-1:0] hit_idx_q, free_idx_q;
	logic      any_exp_q;
	res_t      res_q;
	logic      res_valid_q;

	logic [TICK_W-1:0] inc;
	logic      match, expire, more_exp, scan_end;
	logic [SW-1:0] nxt;
	logic      res_busy, res_load;
	status_t   apply_st;

	assign scan_end = (32'(idx_q) == TIMER_SLOTS - 1);
	assign nxt      = idx_q + SW'(1);
	assign match    = valid_q[idx_q] && (id_q[idx_q] == cmd_q.job_id);
	assign inc      = (ela_q[idx_q] == '1) ? ela_q[idx_q] : ela_q[idx_q] + 1'b1;
	assign expire   = valid_q[idx_q] && (inc >= dur_q[idx_q]);
	assign res_busy = res_valid_q && !res_ready;
	assign res_load = !res_busy &&
		(((state_q == EX_SCAN) && (cmd_q.opcode == OP_TICK) && expire) ||
		 ((state_q == EX_APPLY) && (cmd_q.opcode != OP_NOP)));

	// look ahead for any later expiry, used to mark the final event word
	always_comb begin
		more_exp = 1'b0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			if (i > 32'(idx_q) && valid_q[i] &&
			    (((ela_q[i] == '1) ? ela_q[i] : ela_q[i] + 1'b1) >= dur_q[i]))
				more_exp = 1'b1;
		end
	end

	always_comb begin
		apply_st = ST_OK;
		case (cmd_q.opcode) inside
			OP_START: if (!hit_q && !free_q) apply_st = ST_FULL;
			OP_STOP, OP_RESTART, OP_SETCYC: if (!hit_q) apply_st = ST_NOT_FOUND;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE:  if (!cmd_empty) state_d = EX_SCAN;
			EX_SCAN: begin
				if (cmd_q.opcode == OP_TICK) begin
					if (expire && !(res_valid_q && !res_ready)) state_d = EX_EMIT;
					else if (!expire && scan_end) state_d = EX_IDLE;
				end else if (scan_end) state_d = EX_APPLY;
			end
			EX_APPLY: if (!(res_valid_q && !res_ready)) state_d = EX_IDLE;
			EX_EMIT:  state_d = scan_end ? EX_IDLE : EX_SCAN;
			default:  state_d = EX_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = (state_q == EX_IDLE) && !cmd_empty;
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EX_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			any_exp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				EX_IDLE: begin
					idx_q  <= '0;
					hit_q  <= 1'b0;
					free_q <= 1'b0;
					if (!cmd_empty) cmd_q <= cmd;
				end
				EX_SCAN: begin
					if (cmd_q.opcode == OP_TICK) begin
						if (!expire) begin
							if (valid_q[idx_q]) ela_q[idx_q] <= inc;
							idx_q <= nxt;
						end else if (!(res_valid_q && !res_ready)) begin
							res_q.kind           <= 1'b1;
							res_q.expired_id     <= id_q[idx_q];
							res_q.expired_cyclic <= cyc_q[idx_q];
							res_q.status         <= ST_OK;
							res_q.is_active      <= 1'b0;
							res_q.last           <= !more_exp;
							if (cyc_q[idx_q]) ela_q[idx_q] <= '0;
							else valid_q[idx_q] <= 1'b0;
						end
					end else begin
						if (match && !hit_q) begin
							hit_q <= 1'b1; hit_idx_q <= idx_q;
						end
						if (!valid_q[idx_q] && !free_q) begin
							free_q <= 1'b1; free_idx_q <= idx_q;
						end
						idx_q <= nxt;
					end
				end
				EX_EMIT: idx_q <= nxt;
				EX_APPLY: begin
					if (!(res_valid_q && !res_ready)) begin
						res_q.kind           <= 1'b0;
						res_q.expired_id     <= '0;
						res_q.expired_cyclic <= 1'b0;
						res_q.status         <= apply_st;
						res_q.is_active      <= (cmd_q.opcode == OP_QUERY) && hit_q;
						res_q.last           <= 1'b1;
						case (cmd_q.opcode)
							OP_START: begin
								if (hit_q || free_q) begin
									valid_q[hit_q ? hit_idx_q : free_idx_q] <= 1'b1;
									id_q[hit_q ? hit_idx_q : free_idx_q]    <= cmd_q.job_id;
									dur_q[hit_q ? hit_idx_q : free_idx_q]   <= cmd_q.duration_ticks;
									ela_q[hit_q ? hit_idx_q : free_idx_q]   <= '0;
									cyc_q[hit_q ? hit_idx_q : free_idx_q]   <= cmd_q.cyclic;
								end
							end
							OP_STOP: if (hit_q) valid_q[hit_idx_q] <= 1'b0;
							OP_RESTART: if (hit_q) ela_q[hit_idx_q] <= '0;
							OP_SETCYC: if (hit_q) cyc_q[hit_idx_q] <= cmd_q.cyclic;
							OP_CLEAR: valid_q <= '0;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == EX_IDLE)
		else $error("command taken while busy");
	a_emit_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == EX_EMIT |-> res_valid_q && res_q.kind)
		else $error("emit state without event word");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(res_q))
		else $error("result word lost under stall");
`endif
endmodule

// ===== rtl/multi_slot_timer_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_timer_manager
// Table of software timers driven by a command queue, with an event queue out.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through push/full; one command is taken per edge with
//   push high and full low. Results leave through empty/pop; the oldest
//   word sits on the result ports while empty is low.
//   A two-entry command queue decouples the front from the slot sequencer.
//   Every command walks all TIMER_SLOTS slots through the table's single
//   scan index, one per cycle except that an expiry word holds the walk
//   on its slot; a word left pending while pop is low stalls the next one.
//   A status word is registered after the scan of its command, in the apply
//   step; an expiry word when the scan reaches its slot and the output is free.
//   Reset empties the table and both queues at once.
//   While pop stays low, the sequencer holds at the pending word and the
//   command queue fills; then full rises.
// ----------------------------------------------------------------------------
module multi_slot_timer_manager
	import mstm_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = DEF_TIMER_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [OP_W-1:0]   opcode,
	input  logic [ID_W-1:0]   job_id,
	input  logic [TICK_W-1:0] duration_ticks,
	input  logic              cyclic,
	output logic              empty,
	input  logic              pop,
	output logic              kind,
	output logic [ID_W-1:0]   expired_id,
	output logic              expired_cyclic,
	output logic [ST_W-1:0]   status,
	output logic              is_active,
	output logic              last
);
	cmd_t in_word, q_word;
	logic q_empty, q_pop;
	res_t res;
	logic res_valid;

	assign in_word = '{opcode: op_t'(opcode), job_id: job_id,
	                   duration_ticks: duration_ticks, cyclic: cyclic};

	mstm_cmd_fifo u_fifo (
		.clk, .arst_n, .wr_en(push), .wr_word(in_word), .full,
		.rd_en(q_pop), .rd_word(q_word), .empty(q_empty)
	);

	mstm_engine #(.TIMER_SLOTS(TIMER_SLOTS)) u_engine (
		.clk, .arst_n, .cmd(q_word), .cmd_empty(q_empty), .cmd_pop(q_pop),
		.res, .res_valid, .res_ready(pop)
	);

	assign empty          = !res_valid;
	assign kind           = res.kind;
	assign expired_id     = res.expired_id;
	assign expired_cyclic = res.expired_cyclic;
	assign status         = res.status;
	assign is_active      = res.is_active;
	assign last           = res.last;
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the timer table against a cycle-free model of its slot table, fed
// with directed corner commands and random streams under idling and stalls.
// ----------------------------------------------------------------------------
module tb;
	import mstm_pkg::*;

	localparam int SLOTS = DEF_TIMER_SLOTS;
	localparam int LIMIT = 2000000;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [OP_W-1:0]   opcode;
	logic [ID_W-1:0]   job_id;
	logic [TICK_W-1:0] duration_ticks;
	logic              cyclic;
	logic              empty;
	logic              pop;
	logic              kind;
	logic [ID_W-1:0]   expired_id;
	logic              expired_cyclic;
	logic [ST_W-1:0]   status;
	logic              is_active;
	logic              last;

	multi_slot_timer_manager #(.TIMER_SLOTS(SLOTS)) dut (.*);

	cmd_t cmd_q[$];
	res_t word_q[$];
	bit   t_valid[SLOTS];
	logic [ID_W-1:0]   t_id[SLOTS];
	logic [TICK_W-1:0] t_dur[SLOTS];
	logic [TICK_W-1:0] t_elapsed[SLOTS];
	bit   t_cyc[SLOTS];
	int   errors = 0;
	int   cycles = 0;
	int   send_idle = 0;
	int   recv_stall = 0;
	bit   stim_done = 0;
	logic [ID_W-1:0] id_pool[8];

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic res_t status_word(status_t st, logic act);
		res_t r;
		r = '0;
		r.status = st;
		r.is_active = act;
		r.last = 1'b1;
		return r;
	endfunction

	// Apply one command to the timer table and queue the words it yields.
	function automatic void apply_command(cmd_t c);
		int s;
		int n;
		res_t r;
		s = -1;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (s < 0 && t_valid[i] && t_id[i] == c.job_id) s = i;
		case (c.opcode)
			OP_START: begin
				if (s < 0)
					for (int i = 0; i < SLOTS; i++)
						if (s < 0 && !t_valid[i]) s = i;
				if (s < 0) word_q = {word_q, status_word(ST_FULL, 1'b0)};
				else begin
					t_valid[s] = 1;
					t_id[s] = c.job_id;
					t_dur[s] = c.duration_ticks;
					t_elapsed[s] = '0;
					t_cyc[s] = c.cyclic;
					word_q = {word_q, status_word(ST_OK, 1'b0)};
				end
			end
			OP_STOP, OP_RESTART, OP_SETCYC: begin
				if (s < 0) word_q = {word_q, status_word(ST_NOT_FOUND, 1'b0)};
				else begin
					if (c.opcode == OP_STOP) t_valid[s] = 0;
					else if (c.opcode == OP_RESTART) t_elapsed[s] = '0;
					else t_cyc[s] = c.cyclic;
					word_q = {word_q, status_word(ST_OK, 1'b0)};
				end
			end
			OP_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!t_valid[i]) continue;
					if (t_elapsed[i] != '1) t_elapsed[i]++;
					if (t_elapsed[i] >= t_dur[i]) begin
						r = '0;
						r.kind = 1'b1;
						r.expired_id = t_id[i];
						r.expired_cyclic = t_cyc[i];
						r.status = ST_OK;
						word_q = {word_q, r};
						n++;
						if (t_cyc[i]) t_elapsed[i] = '0;
						else t_valid[i] = 0;
					end
				end
				if (n > 0) word_q[$].last = 1'b1;
			end
			OP_QUERY: word_q = {word_q, status_word(ST_OK, s >= 0)};
			OP_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) t_valid[i] = 0;
				word_q = {word_q, status_word(ST_OK, 1'b0)};
			end
			default: ;
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic add_cmd(op_t op, logic [ID_W-1:0] id, logic [TICK_W-1:0] dur, logic cyc);
		cmd_t c;
		c.opcode = op;
		c.job_id = id;
		c.duration_ticks = dur;
		c.cyclic = cyc;
		cmd_q = {cmd_q, c};
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (push && !full) apply_command('{op_t'(opcode), job_id, duration_ticks, cyclic});
			if ((push && !full) || !push) begin
				if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					push <= 1'b1;
					{opcode, job_id, duration_ticks, cyclic} <= cmd_q.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (word_q.size() == 0) begin
					report("unexpected word", kind, 0);
				end else begin
					res_t w;
					w = word_q.pop_front();
					if (kind !== w.kind) report("kind", kind, w.kind);
					if (expired_id !== w.expired_id) report("expired_id", expired_id, w.expired_id);
					if (expired_cyclic !== w.expired_cyclic)
						report("expired_cyclic", expired_cyclic, w.expired_cyclic);
					if (status !== w.status) report("status", status, w.status);
					if (is_active !== w.is_active) report("is_active", is_active, w.is_active);
					if (last !== w.last) report("last", last, w.last);
				end
			end
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic logic [TICK_W-1:0] rand_dur();
		case ($urandom_range(9))
			0: return $urandom();
			1: return '1;
			2: return '0;
			default: return $urandom_range(6);
		endcase
	endfunction

	task automatic run_phase(int count, int s_idle, int r_stall);
		op_t op;
		int k;
		send_idle = s_idle;
		recv_stall = r_stall;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 35) op = OP_START;
			else if (k < 65) op = OP_TICK;
			else if (k < 72) op = OP_STOP;
			else if (k < 79) op = OP_RESTART;
			else if (k < 86) op = OP_SETCYC;
			else if (k < 95) op = OP_QUERY;
			else if (k < 98) op = OP_CLEAR;
			else op = OP_NOP;
			add_cmd(op, ($urandom_range(9) == 0) ? 16'($urandom()) : id_pool[$urandom_range(7)],
				rand_dur(), $urandom_range(1));
		end
		while (cmd_q.size() > 0 || push) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		opcode = '0;
		job_id = '0;
		duration_ticks = '0;
		cyclic = 1'b0;
		foreach (t_valid[i]) t_valid[i] = 0;
		foreach (id_pool[i]) id_pool[i] = $urandom();
		id_pool[0] = '0;
		id_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// corners: empty table, zero and max durations, table full, replace
		add_cmd(OP_STOP, 16'h0000, '0, 1'b0);
		add_cmd(OP_RESTART, 16'hFFFF, '0, 1'b0);
		add_cmd(OP_SETCYC, 16'h1234, '0, 1'b1);
		add_cmd(OP_QUERY, 16'hFFFF, '0, 1'b0);
		add_cmd(OP_TICK, '0, '0, 1'b0);
		add_cmd(OP_NOP, 16'hFFFF, '1, 1'b1);
		for (int i = 0; i < SLOTS; i++)
			add_cmd(OP_START, (i == 0) ? 16'hFFFF : 16'(i), (i < 2) ? '0 : ((i == 2) ? '1 : 1),
				i[0]);
		add_cmd(OP_START, 16'h5555, 32'h0, 1'b0);
		add_cmd(OP_START, 16'h0003, 32'h2, 1'b1);
		add_cmd(OP_QUERY, 16'h0003, '0, 1'b0);
		add_cmd(OP_TICK, '0, '0, 1'b0);
		add_cmd(OP_CLEAR, '0, '0, 1'b0);
		run_phase(0, 0, 0);
		// saturation: a max-duration timer can not be ticked to the top here,
		// so elapsed saturation is exercised only via the compare path
		run_phase(100, 0, 0);
		run_phase(100, 82, 0);
		run_phase(100, 0, 82);
		run_phase(100, 12, 12);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (word_q.size() > 0 && cycles < LIMIT) @(posedge clk);
		repeat (200) @(posedge clk);
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
		end else if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		wait (cycles >= LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule
